// ===== src/lid_actuator_sequencer_macros.svh =====
// assertion macros for the lid actuator sequencer checker
`ifndef LID_ACTUATOR_SEQUENCER_MACROS_SVH
`define LID_ACTUATOR_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lid actuator sequencer check failed");

// next-cycle implication, disabled during reset
`define LAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lid actuator sequencer check failed");

`endif

// ===== src/las_pkg.sv =====
// shared types and constants of the lid actuator sequencer
package las_pkg;

  localparam int POSITION_WIDTH_DEF = 32;

  localparam int POS_PORT_W = 32;
  localparam int ERR_PORT_W = 32;
  localparam int ENC_W      = 13;
  localparam int SPEED_W    = 16;
  localparam int LIMIT_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_POSITION = 2'd1,
    CMD_SPEED    = 2'd2
  } cmd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_POSITION   = 3'd0,
    REG_CLOSED_POSITION = 3'd1,
    REG_RAMP_STEP       = 3'd2,
    REG_TOGGLE_COOLDOWN = 3'd3,
    REG_STALL_ERROR     = 3'd4,
    REG_STALL_TICKS     = 3'd5,
    REG_UNJAM_TICKS     = 3'd6,
    REG_UNJAM_SPEED     = 3'd7
  } cfg_reg_t;

  // calibration phases
  typedef enum logic [2:0] {
    CAL_IDLE  = 3'b001,
    CAL_DRIVE = 3'b010,
    CAL_ZERO  = 3'b100
  } cal_state_t;

  // configuration defaults
  localparam logic signed [15:0] OPEN_POSITION_RST   = -16'sd2500;
  localparam logic signed [15:0] CLOSED_POSITION_RST = -16'sd150;
  localparam logic [9:0]         RAMP_STEP_RST       = 10'd20;
  localparam logic [9:0]         TOGGLE_COOLDOWN_RST = 10'd300;
  localparam logic [15:0]        STALL_ERROR_RST     = 16'd800;
  localparam logic [11:0]        STALL_TICKS_RST     = 12'd1000;
  localparam logic [9:0]         UNJAM_TICKS_RST     = 10'd100;
  localparam logic [14:0]        UNJAM_SPEED_RST     = 15'd1500;

  // fixed thresholds
  localparam int                  OPEN_FLAG_SET   = -2300;
  localparam int                  OPEN_FLAG_CLEAR = -500;
  localparam int                  CAL_STEP        = 20;
  localparam logic [ERR_PORT_W-1:0] CAL_ERROR_LIMIT = 32'd5000;
  localparam logic [LIMIT_W-1:0]  LIMIT_CALIB     = 14'd8000;
  localparam logic [LIMIT_W-1:0]  LIMIT_NORMAL    = 14'd9000;

endpackage

// ===== src/lid_actuator_sequencer.sv =====
// lid actuator sequencer: request toggle, setpoint ramp, unjam, calibration
// a beat moves from the input register to the result register once the output advances
// throughput: one beat per cycle unless out_stall holds; the registers split the sides
// the tick logic between them is one pass of compares and adders on the state registers
// reset (rst_n low, synchronous) clears tick state and valid flags, loads default config
module lid_actuator_sequencer #(
  parameter int POSITION_WIDTH = las_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,

  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_disabled,
  input  logic                                     in_key_toggle,
  input  logic                                     in_key_modifier,
  input  logic                                     in_chassis_moving,
  input  logic                                     in_chassis_spinning,
  input  logic signed [las_pkg::POS_PORT_W-1:0]    in_position,
  input  logic signed [las_pkg::ERR_PORT_W-1:0]    in_outer_error,
  input  logic        [las_pkg::ENC_W-1:0]         in_encoder,

  output logic                                     out_valid,
  input  logic                                     out_stall,
  output las_pkg::cmd_kind_t                       out_command_kind,
  output logic signed [las_pkg::POS_PORT_W-1:0]    out_position_target,
  output logic signed [las_pkg::SPEED_W-1:0]       out_speed_target,
  output logic        [las_pkg::LIMIT_W-1:0]       out_current_limit,
  output logic                                     out_zero_position,
  output logic        [las_pkg::ENC_W-1:0]         out_encoder_offset,
  output logic                                     out_lid_is_open,
  output logic                                     out_lid_requested_open,
  output logic                                     out_calibrating,
  output logic                                     out_closed_by_motion,

  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic        [las_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic        [las_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import las_pkg::*;

  localparam int PW = POSITION_WIDTH;

  localparam logic signed [PW-1:0] POS_MAX   = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN   = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [PW-1:0] FLAG_SET  = PW'(OPEN_FLAG_SET);
  localparam logic signed [PW-1:0] FLAG_CLR  = PW'(OPEN_FLAG_CLEAR);
  localparam logic signed [PW:0]   CAL_INC   = (PW+1)'(CAL_STEP);

  // configuration registers
  logic signed [15:0] open_position_r;
  logic signed [15:0] closed_position_r;
  logic [9:0]         ramp_step_r;
  logic [9:0]         toggle_cooldown_r;
  logic [15:0]        stall_error_r;
  logic [11:0]        stall_ticks_r;
  logic [9:0]         unjam_ticks_r;
  logic [14:0]        unjam_speed_r;

  // tick state
  logic               open_req_r,    open_req_nxt;
  logic [9:0]         cooldown_r,    cooldown_nxt;
  logic signed [PW-1:0] setpoint_r,  setpoint_nxt;
  logic [11:0]        stall_cnt_r,   stall_cnt_nxt;
  logic               unjam_r,       unjam_nxt;
  logic [9:0]         unjam_cnt_r,   unjam_cnt_nxt;
  logic               open_flag_r,   open_flag_nxt;
  logic               cal_req_r,     cal_req_nxt;
  cal_state_t         cal_state_r,   cal_state_nxt;
  logic               cal_active_r,  cal_active_nxt;
  logic signed [PW-1:0] cal_target_r, cal_target_nxt;
  logic               motion_closed_r, motion_closed_nxt;
  logic [ENC_W-1:0]   enc_latch_r,   enc_latch_nxt;

  // input register
  logic               s1_valid_r;
  logic               s1_disabled_r;
  logic               s1_key_r;
  logic               s1_modk_r;
  logic               s1_moving_r;
  logic               s1_spinning_r;
  logic [POS_PORT_W-1:0]        s1_pos_r;
  logic signed [ERR_PORT_W-1:0] s1_oerr_r;
  logic [ENC_W-1:0]   s1_enc_r;

  // result register
  logic               out_valid_r;
  cmd_kind_t          out_kind_r;
  logic signed [POS_PORT_W-1:0] out_ptgt_r;
  logic signed [SPEED_W-1:0]    out_stgt_r;
  logic [LIMIT_W-1:0] out_limit_r;
  logic               out_zero_r;
  logic [ENC_W-1:0]   out_enc_r;
  logic               out_open_r;
  logic               out_req_r;
  logic               out_cal_r;
  logic               out_motion_r;

  logic               advance;
  logic               fire;

  // tick results
  cmd_kind_t              kind;
  logic signed [PW-1:0]   ptgt;
  logic signed [SPEED_W-1:0] stgt;
  logic                   zero;
  logic signed [PW-1:0]   pos;
  logic signed [PW:0]     pdiff;
  logic [PW:0]            err;
  logic                   changed;
  logic [ERR_PORT_W-1:0]  oerr_abs;
  logic signed [PW-1:0]   cl;
  logic signed [PW-1:0]   op;
  logic signed [PW:0]     step_pos;
  logic signed [PW:0]     step_neg;
  logic signed [SPEED_W-1:0] spd_pos;

  function automatic logic signed [PW-1:0] sat_add(input logic signed [PW-1:0] a,
                                                   input logic signed [PW:0]   b);
    logic signed [PW:0] s;
    s = {a[PW-1], a} + b;
    if (s[PW] != s[PW-1]) begin
      sat_add = s[PW] ? POS_MIN : POS_MAX;
    end else begin
      sat_add = s[PW-1:0];
    end
  endfunction

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;

  assign cl       = PW'(closed_position_r);
  assign op       = PW'(open_position_r);
  assign step_pos = $signed((PW+1)'(ramp_step_r));
  assign step_neg = -step_pos;
  assign spd_pos  = $signed({1'b0, unjam_speed_r});
  assign oerr_abs = s1_oerr_r[ERR_PORT_W-1] ? (~s1_oerr_r + 1'b1) : s1_oerr_r;

  always_comb begin
    open_req_nxt      = open_req_r;
    cooldown_nxt      = cooldown_r;
    setpoint_nxt      = setpoint_r;
    stall_cnt_nxt     = stall_cnt_r;
    unjam_nxt         = unjam_r;
    unjam_cnt_nxt     = unjam_cnt_r;
    open_flag_nxt     = open_flag_r;
    cal_req_nxt       = cal_req_r;
    cal_state_nxt     = cal_state_r;
    cal_active_nxt    = cal_active_r;
    cal_target_nxt    = cal_target_r;
    motion_closed_nxt = motion_closed_r;
    enc_latch_nxt     = enc_latch_r;
    kind              = CMD_NONE;
    ptgt              = '0;
    stgt              = '0;
    zero              = 1'b0;
    changed           = 1'b0;
    pos               = $signed(PW'(s1_pos_r));
    pdiff             = '0;
    err               = '0;

    if (s1_disabled_r || (s1_key_r && s1_modk_r)) begin
      cal_req_nxt = 1'b1;
    end

    if (!s1_disabled_r) begin
      if (cal_req_nxt) begin
        unique case (cal_state_r)
          CAL_DRIVE: begin
            cal_active_nxt = 1'b1;
            cal_target_nxt = sat_add(cal_target_r, CAL_INC);
            kind           = CMD_POSITION;
            ptgt           = cal_target_nxt;
            if (oerr_abs > CAL_ERROR_LIMIT) begin
              cal_state_nxt = CAL_ZERO;
            end
          end
          CAL_ZERO: begin
            enc_latch_nxt  = s1_enc_r;
            zero           = 1'b1;
            pos            = '0;
            kind           = CMD_POSITION;
            ptgt           = '0;
            cal_state_nxt  = CAL_IDLE;
            cal_req_nxt    = 1'b0;
            cal_active_nxt = 1'b0;
            open_req_nxt   = 1'b0;
          end
          default: begin
            cal_target_nxt = pos;
            cal_state_nxt  = CAL_DRIVE;
          end
        endcase
      end

      if (!cal_active_nxt) begin
        pdiff = {pos[PW-1], pos} - {setpoint_r[PW-1], setpoint_r};
        err   = pdiff[PW] ? $unsigned(-pdiff) : $unsigned(pdiff);

        if (!unjam_r) begin
          if (s1_key_r && (cooldown_r == '0)) begin
            open_req_nxt = !open_req_nxt;
            changed      = 1'b1;
            cooldown_nxt = 10'd1;
          end
          if (cooldown_nxt != '0) begin
            cooldown_nxt = (cooldown_nxt >= toggle_cooldown_r) ? '0 : cooldown_nxt + 10'd1;
          end
          if (changed) begin
            setpoint_nxt = pos;
          end
          if (!open_req_nxt) begin
            setpoint_nxt = (setpoint_nxt <= cl) ? sat_add(setpoint_nxt, step_pos) : cl;
          end else begin
            setpoint_nxt = (setpoint_nxt >= op) ? sat_add(setpoint_nxt, step_neg) : op;
          end
          kind = CMD_POSITION;
          ptgt = setpoint_nxt;
        end

        // stall detection, equal error keeps the count
        if (err > (PW+1)'(stall_error_r)) begin
          stall_cnt_nxt = stall_cnt_r + 12'd1;
          if (stall_cnt_nxt >= stall_ticks_r) begin
            stall_cnt_nxt = '0;
            unjam_nxt     = 1'b1;
          end
        end else if (err < (PW+1)'(stall_error_r)) begin
          stall_cnt_nxt = '0;
        end

        if (unjam_nxt) begin
          unjam_cnt_nxt = unjam_cnt_r + 10'd1;
          kind          = CMD_SPEED;
          ptgt          = '0;
          stgt          = open_req_nxt ? spd_pos : -spd_pos;
          if (unjam_cnt_nxt >= unjam_ticks_r) begin
            unjam_nxt     = 1'b0;
            setpoint_nxt  = pos;
            unjam_cnt_nxt = '0;
          end
        end

        if (pos < FLAG_SET) begin
          open_flag_nxt = 1'b1;
        end
        if (pos > FLAG_CLR) begin
          open_flag_nxt = 1'b0;
        end
        if (s1_moving_r && open_flag_nxt && !s1_spinning_r) begin
          motion_closed_nxt = 1'b1;
          open_req_nxt      = 1'b0;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_position_r   <= OPEN_POSITION_RST;
      closed_position_r <= CLOSED_POSITION_RST;
      ramp_step_r       <= RAMP_STEP_RST;
      toggle_cooldown_r <= TOGGLE_COOLDOWN_RST;
      stall_error_r     <= STALL_ERROR_RST;
      stall_ticks_r     <= STALL_TICKS_RST;
      unjam_ticks_r     <= UNJAM_TICKS_RST;
      unjam_speed_r     <= UNJAM_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OPEN_POSITION:   open_position_r   <= $signed(cfg_data);
        REG_CLOSED_POSITION: closed_position_r <= $signed(cfg_data);
        REG_RAMP_STEP:       ramp_step_r       <= cfg_data[9:0];
        REG_TOGGLE_COOLDOWN: toggle_cooldown_r <= cfg_data[9:0];
        REG_STALL_ERROR:     stall_error_r     <= cfg_data;
        REG_STALL_TICKS:     stall_ticks_r     <= cfg_data[11:0];
        REG_UNJAM_TICKS:     unjam_ticks_r     <= cfg_data[9:0];
        REG_UNJAM_SPEED:     unjam_speed_r     <= cfg_data[14:0];
      endcase
    end
  end

  // tick state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_req_r      <= 1'b0;
      cooldown_r      <= '0;
      setpoint_r      <= '0;
      stall_cnt_r     <= '0;
      unjam_r         <= 1'b0;
      unjam_cnt_r     <= '0;
      open_flag_r     <= 1'b0;
      cal_req_r       <= 1'b0;
      cal_state_r     <= CAL_IDLE;
      cal_active_r    <= 1'b0;
      cal_target_r    <= '0;
      motion_closed_r <= 1'b0;
      enc_latch_r     <= '0;
    end else if (fire) begin
      open_req_r      <= open_req_nxt;
      cooldown_r      <= cooldown_nxt;
      setpoint_r      <= setpoint_nxt;
      stall_cnt_r     <= stall_cnt_nxt;
      unjam_r         <= unjam_nxt;
      unjam_cnt_r     <= unjam_cnt_nxt;
      open_flag_r     <= open_flag_nxt;
      cal_req_r       <= cal_req_nxt;
      cal_state_r     <= cal_state_nxt;
      cal_active_r    <= cal_active_nxt;
      cal_target_r    <= cal_target_nxt;
      motion_closed_r <= motion_closed_nxt;
      enc_latch_r     <= enc_latch_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_disabled_r <= in_disabled;
      s1_key_r      <= in_key_toggle;
      s1_modk_r     <= in_key_modifier;
      s1_moving_r   <= in_chassis_moving;
      s1_spinning_r <= in_chassis_spinning;
      s1_pos_r      <= in_position;
      s1_oerr_r     <= in_outer_error;
      s1_enc_r      <= in_encoder;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind_r   <= kind;
      out_ptgt_r   <= POS_PORT_W'(ptgt);
      out_stgt_r   <= stgt;
      out_limit_r  <= cal_active_nxt ? LIMIT_CALIB : LIMIT_NORMAL;
      out_zero_r   <= zero;
      out_enc_r    <= enc_latch_nxt;
      out_open_r   <= open_flag_nxt;
      out_req_r    <= open_req_nxt;
      out_cal_r    <= cal_active_nxt;
      out_motion_r <= motion_closed_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_command_kind       = out_kind_r;
  assign out_position_target    = out_ptgt_r;
  assign out_speed_target       = out_stgt_r;
  assign out_current_limit      = out_limit_r;
  assign out_zero_position      = out_zero_r;
  assign out_encoder_offset     = out_enc_r;
  assign out_lid_is_open        = out_open_r;
  assign out_lid_requested_open = out_req_r;
  assign out_calibrating        = out_cal_r;
  assign out_closed_by_motion   = out_motion_r;

endmodule

// ===== src/las_checker.sv =====
// port-level checks for the lid actuator sequencer, bound to the top level
`include "lid_actuator_sequencer_macros.svh"

module las_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  las_pkg::cmd_kind_t                    out_command_kind,
  input  logic signed [las_pkg::POS_PORT_W-1:0] out_position_target,
  input  logic signed [las_pkg::SPEED_W-1:0]    out_speed_target,
  input  logic        [las_pkg::LIMIT_W-1:0]    out_current_limit,
  input  logic                                  out_zero_position,
  input  logic        [las_pkg::ENC_W-1:0]      out_encoder_offset,
  input  logic                                  out_calibrating
);
  import las_pkg::*;

  // a stalled result beat holds
  `LAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_command_kind) && $stable(out_position_target) && $stable(out_speed_target) && $stable(out_encoder_offset))

  // calibration drive never commands speed and runs at reduced limit
  `LAS_ASSERT_NOW(a_cal_drive, clk, rst_n, out_valid && out_calibrating, out_command_kind != CMD_SPEED && out_current_limit == LIMIT_CALIB)

  `LAS_ASSERT_NOW(a_limit_normal, clk, rst_n, out_valid && !out_calibrating, out_current_limit == LIMIT_NORMAL)

  // unused command value stays zero
  `LAS_ASSERT_NOW(a_unused_zero, clk, rst_n, out_valid, (out_command_kind == CMD_SPEED || out_speed_target == '0) && (out_command_kind == CMD_POSITION || out_position_target == '0))

  `LAS_ASSERT_NOW(a_zero_ends_cal, clk, rst_n, out_valid && out_zero_position, !out_calibrating)

endmodule

bind lid_actuator_sequencer las_checker u_las_checker (.*);
